// ===== sv/bbc_pkg.sv =====
package bbc_pkg;

  // Defaults for the top-level parameters
  localparam int DEFAULT_STACK_DEPTH = 256;
  localparam int DEFAULT_COUNT_WIDTH = 16;

  // Result fields are fixed at 16 bits and saturate there
  localparam int OUT_W = 16;

  // Bracket characters
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic  closing;
    kind_t kind;
  } bbc_class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DRAIN,
    ST_FINISH
  } bbc_state_t;

  function automatic bbc_class_t classify(input logic [7:0] ch);
    bbc_class_t c;
    c.closing = 1'b0;
    c.kind    = KIND_NONE;
    case (ch)
      CH_LPAREN:  c.kind = KIND_ROUND;
      CH_LSQUARE: c.kind = KIND_SQUARE;
      CH_LCURLY:  c.kind = KIND_CURLY;
      CH_RPAREN: begin
        c.kind    = KIND_ROUND;
        c.closing = 1'b1;
      end
      CH_RSQUARE: begin
        c.kind    = KIND_SQUARE;
        c.closing = 1'b1;
      end
      CH_RCURLY: begin
        c.kind    = KIND_CURLY;
        c.closing = 1'b1;
      end
      default: c.kind = KIND_NONE;
    endcase
    return c;
  endfunction

  // One bit per tally: round, square, curly
  function automatic logic [2:0] kind_onehot(input kind_t k);
    logic [2:0] v;
    case (k)
      KIND_ROUND:  v = 3'b001;
      KIND_SQUARE: v = 3'b010;
      KIND_CURLY:  v = 3'b100;
      default:     v = 3'b000;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/bbc_if.sv =====
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_byte;
  logic       last;

  modport source (output valid, symbol_byte, last, input ready);
  modport sink (input valid, symbol_byte, last, output ready);
endinterface

interface bbc_out_if import bbc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] round_count;
  logic [OUT_W-1:0] square_count;
  logic [OUT_W-1:0] curly_count;
  logic             balanced;
  logic             overflow;

  modport source (output valid, round_count, square_count, curly_count, balanced, overflow,
                  input ready);
  modport sink (input valid, round_count, square_count, curly_count, balanced, overflow,
                output ready);
endinterface

// ===== sv/bracket_balance_checker.sv =====
// Throughput: one beat per cycle for non-brackets, opening brackets and closers on an
//   empty stack, if not last; a closer that pops stalls input for a stack read, then compare.
// Last beat: drains the stack after any pop, one stack read per entry; the result then
//   loads into the output register from ST_FINISH once that register is free.
// Reset (rst_n low, synchronous): empties the stack, clears tallies and overflow,
//   drops any pending result; stack memory contents are not cleared.
module bracket_balance_checker import bbc_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input logic       clk,
  input logic       rst_n,
  bbc_in_if.sink    in_bus,
  bbc_out_if.source out_bus
);

  // Fill counter must hold STACK_DEPTH itself; addresses need one bit less at powers of two
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int EW = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [FW-1:0] FILL_FULL = FW'(STACK_DEPTH);
  localparam logic [EW-1:0] OUT_LIMIT = EW'({OUT_W{1'b1}});

  // Clamp a tally to the 16-bit result field
  function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] t);
    logic [EW-1:0] ext;
    ext = EW'(t);
    return (ext > OUT_LIMIT) ? {OUT_W{1'b1}} : ext[OUT_W-1:0];
  endfunction

  // Stack memory: one write port, one registered read port
  logic [1:0] stack_mem [STACK_DEPTH];
  logic [1:0] rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[mem_raddr];
    end
  end

  // Control and tally state
  bbc_state_t state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] drain_idx_r, drain_idx_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          ovf_r, ovf_nxt;
  logic          last_r, last_nxt;
  kind_t         close_kind_r, close_kind_nxt;
  logic [COUNT_WIDTH-1:0] tally_r [3];
  logic [COUNT_WIDTH-1:0] tally_nxt [3];
  logic [2:0]    bump;
  logic          clear_all;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_load;
  logic [OUT_W-1:0] out_round_r, out_square_r, out_curly_r;
  logic             out_bal_r, out_ovf_r;

  bbc_class_t in_cls;
  logic       in_fire;
  logic       out_fire;
  kind_t      top_kind;

  assign in_cls   = classify(in_bus.symbol_byte);
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_valid_r && out_bus.ready;
  assign top_kind = kind_t'(rd_data_r);

  assign in_bus.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    drain_idx_nxt  = drain_idx_r;
    rd_pend_nxt    = rd_pend_r;
    ovf_nxt        = ovf_r;
    last_nxt       = last_r;
    close_kind_nxt = close_kind_r;
    bump           = 3'b000;
    mem_we         = 1'b0;
    mem_waddr      = fill_r[AW-1:0];
    mem_wdata      = in_cls.kind;
    mem_re         = 1'b0;
    mem_raddr      = fill_r[AW-1:0];
    out_load       = 1'b0;
    clear_all      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cls.kind != KIND_NONE && !in_cls.closing) begin
            // Push, or drop on a full stack and remember it
            if (fill_r != FILL_FULL) begin
              mem_we   = 1'b1;
              fill_nxt = fill_r + FW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (in_cls.kind != KIND_NONE && fill_r == '0) begin
            bump = kind_onehot(in_cls.kind);
          end
          if (in_cls.kind != KIND_NONE && in_cls.closing && fill_r != '0) begin
            // Fetch the top; compare next cycle
            mem_re         = 1'b1;
            mem_raddr      = AW'(fill_r - FW'(1));
            close_kind_nxt = in_cls.kind;
            last_nxt       = in_bus.last;
            state_nxt      = ST_POP;
          end else if (in_bus.last) begin
            drain_idx_nxt = '0;
            rd_pend_nxt   = 1'b0;
            state_nxt     = ST_DRAIN;
          end
        end
      end

      ST_POP: begin
        fill_nxt = fill_r - FW'(1);
        if (top_kind != close_kind_r) begin
          bump = kind_onehot(top_kind) | kind_onehot(close_kind_r);
        end
        if (last_r) begin
          drain_idx_nxt = '0;
          rd_pend_nxt   = 1'b0;
          state_nxt     = ST_DRAIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_DRAIN: begin
        // Walk entries bottom to top; tally each one in the cycle after its read
        if (rd_pend_r) begin
          bump = kind_onehot(top_kind);
        end
        if (drain_idx_r != fill_r) begin
          mem_re        = 1'b1;
          mem_raddr     = drain_idx_r[AW-1:0];
          drain_idx_nxt = drain_idx_r + FW'(1);
          rd_pend_nxt   = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          if (!rd_pend_r) begin
            state_nxt = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_bus.ready) begin
          out_load  = 1'b1;
          clear_all = 1'b1;
          fill_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Saturating tallies; two distinct kinds may advance in one cycle
    for (int k = 0; k < 3; k++) begin
      if (clear_all) begin
        tally_nxt[k] = '0;
      end else if (bump[k] && tally_r[k] != CNT_MAX) begin
        tally_nxt[k] = tally_r[k] + COUNT_WIDTH'(1);
      end else begin
        tally_nxt[k] = tally_r[k];
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      drain_idx_r  <= '0;
      rd_pend_r    <= 1'b0;
      ovf_r        <= 1'b0;
      last_r       <= 1'b0;
      close_kind_r <= KIND_NONE;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        tally_r[k] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      drain_idx_r  <= drain_idx_nxt;
      rd_pend_r    <= rd_pend_nxt;
      ovf_r        <= ovf_nxt;
      last_r       <= last_nxt;
      close_kind_r <= close_kind_nxt;
      out_valid_r  <= out_valid_nxt;
      for (int k = 0; k < 3; k++) begin
        tally_r[k] <= tally_nxt[k];
      end
    end
  end

  // Result payload: captured from final tallies, held while the beat stalls
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_round_r  <= sat_out(tally_r[0]);
      out_square_r <= sat_out(tally_r[1]);
      out_curly_r  <= sat_out(tally_r[2]);
      out_bal_r    <= (tally_r[0] == '0) && (tally_r[1] == '0) && (tally_r[2] == '0);
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.round_count  = out_round_r;
  assign out_bus.square_count = out_square_r;
  assign out_bus.curly_count  = out_curly_r;
  assign out_bus.balanced     = out_bal_r;
  assign out_bus.overflow     = out_ovf_r;

endmodule

// ===== sv/bbc_checker.sv =====
module bbc_checker import bbc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_round,
  input logic [OUT_W-1:0] out_square,
  input logic [OUT_W-1:0] out_curly,
  input logic             out_balanced,
  input logic             out_overflow
);

  logic       in_last_fire;
  logic       out_fire;
  logic [1:0] owed_r;

  assign in_last_fire = in_valid && in_ready && in_last;
  assign out_fire     = out_valid && out_ready;

  // Results owed: last beats taken minus result beats delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= '0;
    end else if (in_last_fire && !out_fire) begin
      owed_r <= owed_r + 2'd1;
    end else if (out_fire && !in_last_fire) begin
      owed_r <= owed_r - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_round) && $stable(out_square)
      && $stable(out_curly) && $stable(out_balanced) && $stable(out_overflow))
    else $error("stalled result payload changed");

  a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_balanced == ((out_round == '0) && (out_square == '0)
      && (out_curly == '0))))
    else $error("balanced flag disagrees with counts");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (owed_r != 2'd0) && (owed_r != 2'd3))
    else $error("result beat without a matching last beat");

  a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_last_fire |=> !in_ready)
    else $error("input taken while draining");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .in_last      (in_bus.last),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_round    (out_bus.round_count),
  .out_square   (out_bus.square_count),
  .out_curly    (out_bus.curly_count),
  .out_balanced (out_bus.balanced),
  .out_overflow (out_bus.overflow)
);
